FILE: hdl/tpsd_pkg.sv
// Shared types, register indexes, event codes and reset values for the tile map stream decoder.
package tpsd_pkg;

  localparam int MAP_ENTRIES_DEFAULT = 1024;
  // Address field of a queued command; wide enough for the largest map of 4096 entries.
  localparam int ADDR_W_MAX = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int READ_INDEX_W = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_BASE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIT_THRESH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_CODE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_CODE   = 2'd3;

  localparam logic [15:0] MAP_BASE_RESET   = 16'h9800;
  localparam logic [7:0]  LIT_THRESH_RESET = 8'd80;
  localparam logic [7:0]  FRAME_CODE_RESET = 8'hFF;
  localparam logic [7:0]  END_CODE_RESET   = 8'hEE;

  localparam logic [2:0] EV_OK       = 3'd0;
  localparam logic [2:0] EV_FRAME    = 3'd1;
  localparam logic [2:0] EV_END      = 3'd2;
  localparam logic [2:0] EV_ADDR_ERR = 3'd3;
  localparam logic [2:0] EV_IGNORED  = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic                    kind;
    logic [7:0]              stream_byte;
    logic [READ_INDEX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tile_value;
    logic [2:0]  event_res;
    logic [15:0] frame_number;
  } out_item_t;

  typedef struct packed {
    logic [15:0] map_base_address;
    logic [7:0]  literal_threshold;
    logic [7:0]  frame_marker_code;
    logic [7:0]  stream_end_code;
  } cfg_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [ADDR_W_MAX-1:0] addr;
    logic [7:0]            value;
    logic [7:0]            count;
    logic [2:0]            event_res;
    logic [15:0]           frame_number;
  } cmd_t;

endpackage

FILE: hdl/tpsd_front.sv
// Front end: accepts words, parses the packet stream and issues map commands.
module tpsd_front #(
  parameter int MAP_ENTRIES = tpsd_pkg::MAP_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  tpsd_pkg::cfg_t     cfg,
  input  logic               clearing,
  input  logic               item_valid,
  output logic               item_ready,
  input  tpsd_pkg::in_item_t item,
  input  logic               q_full,
  output logic               q_push,
  output tpsd_pkg::cmd_t     q_cmd
);
  import tpsd_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int IW = READ_INDEX_W + 3;
  localparam int FOLDS = ((1 << READ_INDEX_W) - 1) / MAP_ENTRIES;

  typedef enum logic [5:0] {
    PH_COMMAND    = 6'b000001,
    PH_ADDR_LOW   = 6'b000010,
    PH_LENGTH     = 6'b000100,
    PH_LITERAL    = 6'b001000,
    PH_FILL_VALUE = 6'b010000,
    PH_HALTED     = 6'b100000
  } phase_t;

  phase_t        phase, phase_next;
  logic [7:0]    addr_high, addr_high_next;
  logic [AW-1:0] wp, wp_next;
  logic [7:0]    rem, rem_next;
  logic [15:0]   frames, frames_next;

  logic [16:0]   offset;
  logic [AW:0]   fill_sum;
  logic [AW:0]   fill_wrapped;
  logic [IW-1:0] ridx;
  logic [AW-1:0] wp_inc;
  logic [7:0]    b;

  assign item_ready = !clearing && !q_full;
  assign q_push     = item_valid && item_ready;
  assign b          = item.stream_byte;

  always_comb begin
    phase_next     = phase;
    addr_high_next = addr_high;
    wp_next        = wp;
    rem_next       = rem;
    frames_next    = frames;

    offset = {1'b0, addr_high, b} - {1'b0, cfg.map_base_address};
    fill_sum = {1'b0, wp} + (AW+1)'(rem);
    if (fill_sum >= (AW+1)'(MAP_ENTRIES)) begin
      fill_wrapped = fill_sum - (AW+1)'(MAP_ENTRIES);
    end else begin
      fill_wrapped = fill_sum;
    end
    wp_inc = (wp == AW'(MAP_ENTRIES - 1)) ? '0 : wp + 1'b1;

    // Fold the read index into the map; FOLDS subtractions, (2**READ_INDEX_W - 1) / MAP_ENTRIES, suffice.
    ridx = IW'(item.read_index);
    for (int i = 0; i < FOLDS; i++) begin
      if (ridx >= IW'(MAP_ENTRIES)) begin
        ridx = ridx - IW'(MAP_ENTRIES);
      end
    end

    q_cmd.op        = OP_NONE;
    q_cmd.addr      = ADDR_W_MAX'(wp);
    q_cmd.value     = b;
    q_cmd.count     = 8'd0;
    q_cmd.event_res = EV_OK;

    if (item.kind) begin
      q_cmd.op   = OP_READ;
      q_cmd.addr = ADDR_W_MAX'(ridx[AW-1:0]);
    end else begin
      case (phase)
        PH_COMMAND: begin
          if (b == cfg.frame_marker_code) begin
            if (frames != 16'hFFFF) begin
              frames_next = frames + 16'd1;
            end
            q_cmd.event_res = EV_FRAME;
          end else if (b == cfg.stream_end_code) begin
            phase_next      = PH_HALTED;
            q_cmd.event_res = EV_END;
          end else begin
            addr_high_next = b;
            phase_next     = PH_ADDR_LOW;
          end
        end
        PH_ADDR_LOW: begin
          if (offset[16] || (offset[15:0] > 16'(MAP_ENTRIES - 1))) begin
            phase_next      = PH_HALTED;
            q_cmd.event_res = EV_ADDR_ERR;
          end else begin
            wp_next    = offset[AW-1:0];
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (b > cfg.literal_threshold) begin
            rem_next   = b - cfg.literal_threshold;
            phase_next = PH_LITERAL;
          end else begin
            rem_next   = b;
            phase_next = PH_FILL_VALUE;
          end
        end
        PH_LITERAL: begin
          q_cmd.op    = OP_WRITE;
          q_cmd.count = 8'd1;
          wp_next     = wp_inc;
          rem_next    = rem - 8'd1;
          if (rem == 8'd1) begin
            phase_next = PH_COMMAND;
          end
        end
        PH_FILL_VALUE: begin
          q_cmd.op    = OP_WRITE;
          q_cmd.count = rem;
          wp_next     = fill_wrapped[AW-1:0];
          rem_next    = 8'd0;
          phase_next  = PH_COMMAND;
        end
        PH_HALTED: begin
          q_cmd.event_res = EV_IGNORED;
        end
        default: begin
          q_cmd.event_res = EV_IGNORED;
        end
      endcase
    end

    q_cmd.frame_number = frames_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_COMMAND;
      addr_high <= '0;
      wp        <= '0;
      rem       <= '0;
      frames    <= '0;
    end else if (q_push) begin
      phase     <= phase_next;
      addr_high <= addr_high_next;
      wp        <= wp_next;
      rem       <= rem_next;
      frames    <= frames_next;
    end
  end

endmodule

FILE: hdl/tpsd_queue.sv
// Short command queue between the parsing front end and the map back end.
module tpsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tpsd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tpsd_pkg::cmd_t head
);
  import tpsd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill;

  assign full      = (fill == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/tpsd_back.sv
// Back end: owns the tile memory, clears it after reset and carries out queued commands.
module tpsd_back #(
  parameter int MAP_ENTRIES = tpsd_pkg::MAP_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tpsd_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                clearing,
  output logic                result_valid,
  input  logic                result_ready,
  output tpsd_pkg::out_item_t result
);
  import tpsd_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] wk_addr, wk_addr_next;
  logic [7:0]    wk_count, wk_count_next;
  logic [7:0]    wk_value, wk_value_next;
  logic [2:0]    wk_event, wk_event_next;
  logic [15:0]   wk_frame, wk_frame_next;

  logic [7:0]    mem [MAP_ENTRIES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic          slot_free, out_load;
  out_item_t     out_data;
  logic [AW-1:0] wk_addr_inc;

  assign clearing    = (state == ST_CLEAR);
  assign slot_free   = !result_valid || result_ready;
  assign wk_addr_inc = (wk_addr == AW'(MAP_ENTRIES - 1)) ? '0 : wk_addr + 1'b1;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    wk_addr_next  = wk_addr;
    wk_count_next = wk_count;
    wk_value_next = wk_value;
    wk_event_next = wk_event;
    wk_frame_next = wk_frame;
    mem_we        = 1'b0;
    mem_waddr     = wk_addr;
    mem_wdata     = wk_value;
    mem_re        = 1'b0;
    mem_raddr     = q_head.addr[AW-1:0];
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_data.tile_value   = 8'd0;
    out_data.event_res    = wk_event;
    out_data.frame_number = wk_frame;

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'd0;
        if (clr_addr == AW'(MAP_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          wk_addr_next  = q_head.addr[AW-1:0];
          wk_count_next = q_head.count;
          wk_value_next = q_head.value;
          wk_event_next = q_head.event_res;
          wk_frame_next = q_head.frame_number;
          if (q_head.op == OP_READ) begin
            mem_re     = 1'b1;
            state_next = ST_READ;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        // The last entry of a run is written in the same cycle as the result is posted.
        if (wk_count > 8'd1) begin
          mem_we        = 1'b1;
          wk_addr_next  = wk_addr_inc;
          wk_count_next = wk_count - 8'd1;
        end else if (slot_free) begin
          mem_we     = (wk_count != 8'd0);
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_data.tile_value = mem_rdata;
          out_load            = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    wk_addr  <= wk_addr_next;
    wk_count <= wk_count_next;
    wk_value <= wk_value_next;
    wk_event <= wk_event_next;
    wk_frame <= wk_frame_next;
    if (out_load) begin
      result <= out_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/tilemap_packet_stream_decoder.sv
// The back end takes each command from the queue and carries it out before it takes the next;
// a fill of n entries keeps the back end busy while a four-deep queue absorbs input.
// Reset: synchronous; afterwards the tile memory is cleared one entry per cycle, and
// item_ready stays low until the clearing is done. Configuration writes are always taken.
module tilemap_packet_stream_decoder #(
  parameter int MAP_ENTRIES = tpsd_pkg::MAP_ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tpsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tpsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  tpsd_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output tpsd_pkg::out_item_t                 result
);
  import tpsd_pkg::*;

  cfg_t cfg;
  logic clearing;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_base_address  <= MAP_BASE_RESET;
      cfg.literal_threshold <= LIT_THRESH_RESET;
      cfg.frame_marker_code <= FRAME_CODE_RESET;
      cfg.stream_end_code   <= END_CODE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAP_BASE:   cfg.map_base_address  <= cfg_data;
        CFG_LIT_THRESH: cfg.literal_threshold <= cfg_data[7:0];
        CFG_FRAME_CODE: cfg.frame_marker_code <= cfg_data[7:0];
        CFG_END_CODE:   cfg.stream_end_code   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  tpsd_front #(.MAP_ENTRIES(MAP_ENTRIES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  tpsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tpsd_back #(.MAP_ENTRIES(MAP_ENTRIES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: hdl/tpsd_checker.sv
// Port-level checks for the tile map stream decoder, bound to the top level.
module tpsd_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input tpsd_pkg::out_item_t result
);
  import tpsd_pkg::*;

  // A stalled result word must hold still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.event_res <= EV_IGNORED)
    else $error("event code out of range");

  // Only read words carry a tile value, and those always report success.
  a_tile_only_on_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res != EV_OK) |-> result.tile_value == 8'd0)
    else $error("tile value on a word that was not a read");

  // The memory clearing pass keeps the input closed straight after reset.
  a_closed_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item_ready)
    else $error("input opened before the tile memory was cleared");

endmodule

bind tilemap_packet_stream_decoder tpsd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the tile map packet stream decoder.
`timescale 1ns / 1ps

module tb_top;
  import tpsd_pkg::*;

  typedef enum logic [2:0] {
    WANT_CMD, WANT_ADDR_LO, WANT_LENGTH, IN_LITERAL, IN_FILL, HALTED
  } parse_t;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;

  // Copy of the decoder state, advanced once per accepted word.
  logic [7:0]  tile_copy [MAP_ENTRIES_DEFAULT];
  parse_t      parse_copy;
  logic [7:0]  addr_hi_copy;
  logic [9:0]  wptr_copy;
  logic [7:0]  run_left;
  logic [15:0] frames_copy;
  cfg_t        regs_copy;

  out_item_t awaited_results[$];
  in_item_t  stim_words[$];
  row_t      plan[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned faults = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  bit          ended_by_marker;

  tilemap_packet_stream_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned cap(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic out_item_t decode_word(in_item_t w);
    out_item_t   r;
    int unsigned addr;
    int unsigned top;
    r = '0;
    r.event_res = EV_OK;
    if (w.kind) begin
      r.tile_value = tile_copy[w.read_index];
    end else begin
      case (parse_copy)
        WANT_CMD: begin
          if (w.stream_byte == regs_copy.frame_marker_code) begin
            if (frames_copy != 16'hFFFF) frames_copy++;
            r.event_res = EV_FRAME;
          end else if (w.stream_byte == regs_copy.stream_end_code) begin
            parse_copy = HALTED;
            r.event_res = EV_END;
          end else begin
            addr_hi_copy = w.stream_byte;
            parse_copy = WANT_ADDR_LO;
          end
        end
        WANT_ADDR_LO: begin
          addr = {addr_hi_copy, w.stream_byte};
          top = regs_copy.map_base_address + 32'd1023;
          if (addr < regs_copy.map_base_address || addr > top) begin
            parse_copy = HALTED;
            r.event_res = EV_ADDR_ERR;
          end else begin
            wptr_copy = 10'(addr - regs_copy.map_base_address);
            parse_copy = WANT_LENGTH;
          end
        end
        WANT_LENGTH: begin
          if (w.stream_byte > regs_copy.literal_threshold) begin
            run_left = w.stream_byte - regs_copy.literal_threshold;
            parse_copy = IN_LITERAL;
          end else begin
            run_left = w.stream_byte;
            parse_copy = IN_FILL;
          end
        end
        IN_LITERAL: begin
          tile_copy[wptr_copy] = w.stream_byte;
          wptr_copy++;
          run_left--;
          if (run_left == 8'd0) parse_copy = WANT_CMD;
        end
        IN_FILL: begin
          repeat (run_left) begin
            tile_copy[wptr_copy] = w.stream_byte;
            wptr_copy++;
          end
          run_left = 8'd0;
          parse_copy = WANT_CMD;
        end
        default: r.event_res = EV_IGNORED;
      endcase
    end
    r.frame_number = frames_copy;
    return r;
  endfunction

  function automatic in_item_t stream_word(logic [7:0] b);
    in_item_t w;
    w.kind = 1'b0;
    w.stream_byte = b;
    w.read_index = 10'($urandom);
    return w;
  endfunction

  function automatic in_item_t read_word(logic [9:0] idx);
    in_item_t w;
    w.kind = 1'b1;
    w.stream_byte = 8'($urandom);
    w.read_index = idx;
    return w;
  endfunction

  function automatic void add_row(in_item_t w, bit typed, out_item_t res);
    row_t r;
    r.w = w;
    r.typed = typed;
    r.res = res;
    plan.push_back(r);
  endfunction

  // Data bytes now and then carry a marker code, which must be stored as data.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0: return regs_copy.frame_marker_code;
      1: return regs_copy.stream_end_code;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    if ($urandom_range(99) < 12) stim_words.push_back(read_word(10'($urandom)));
    stim_words.push_back(stream_word(b));
  endfunction

  // Appends well-formed packets with random content, all inside the map window.
  function automatic void queue_packets(int unsigned n);
    int unsigned lo;
    int unsigned hi;
    int unsigned addr;
    int unsigned room;
    int unsigned k;
    logic [7:0]  hb;
    bit          found;
    lo = regs_copy.map_base_address;
    hi = cap(lo + 1023, 32'hFFFF);
    room = 255 - regs_copy.literal_threshold;
    while (stim_words.size() < n) begin
      found = 1'b0;
      if ($urandom_range(99) >= 8) begin
        repeat (8) begin
          if (!found) begin
            addr = $urandom_range(hi, lo);
            hb = addr[15:8];
            found = hb != regs_copy.frame_marker_code && hb != regs_copy.stream_end_code;
          end
        end
      end
      if (!found) begin
        queue_byte(regs_copy.frame_marker_code);
      end else begin
        queue_byte(hb);
        queue_byte(addr[7:0]);
        if (room != 0 && $urandom_range(1) == 1) begin
          k = ($urandom_range(19) == 0) ? $urandom_range(room, 1)
                                         : $urandom_range(cap(room, 8), 1);
          queue_byte(8'(regs_copy.literal_threshold + k));
          repeat (k) queue_byte(payload_byte());
        end else begin
          k = ($urandom_range(9) == 0) ? $urandom_range(regs_copy.literal_threshold, 0)
                                        : $urandom_range(cap(regs_copy.literal_threshold, 6), 0);
          queue_byte(8'(k));
          queue_byte(payload_byte());
        end
      end
    end
  endfunction

  task automatic send_word(in_item_t w, bit typed, out_item_t typed_res);
    out_item_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    predicted = decode_word(w);
    awaited_results.push_back(typed ? typed_res : predicted);
    words_sent++;
  endtask

  task automatic send_queued();
    while (stim_words.size() != 0) send_word(stim_words.pop_front(), 1'b0, '0);
  endtask

  // Drops valid and waits until every word sent so far has produced its result.
  task automatic settle();
    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(CFG_MAP_BASE, c.map_base_address);
    write_reg(CFG_LIT_THRESH, {8'h00, c.literal_threshold});
    write_reg(CFG_FRAME_CODE, {8'h00, c.frame_marker_code});
    write_reg(CFG_END_CODE, {8'h00, c.stream_end_code});
    cfg_write <= 1'b0;
    regs_copy = c;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      if (faults < 10) $display("%0t: unexpected result %p", $realtime, got);
      faults++;
    end else begin
      want = awaited_results.pop_front();
      if (got.tile_value !== want.tile_value || got.event_res !== want.event_res ||
          got.frame_number !== want.frame_number) begin
        if (faults < 10) $display("%0t: expected %p, got %p", $realtime, want, got);
        faults++;
      end
    end
  endtask

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && result_valid && result_ready) check_result(result);
  end

  initial begin
    foreach (tile_copy[i]) tile_copy[i] = 8'h00;
    parse_copy = WANT_CMD;
    addr_hi_copy = 8'h00;
    wptr_copy = 10'd0;
    run_left = 8'd0;
    frames_copy = 16'd0;
    regs_copy = '{MAP_BASE_RESET, LIT_THRESH_RESET, FRAME_CODE_RESET, END_CODE_RESET};

    // Reset register values: a literal run over the top of the map wraps to entry 0,
    // a fill at the threshold length, and a fill of length zero that writes nothing.
    add_row(read_word(10'd0), 1'b1, '{8'h00, EV_OK, 16'd0});
    add_row(read_word(10'd1023), 1'b1, '{8'h00, EV_OK, 16'd0});
    add_row(stream_word(8'hFF), 1'b1, '{8'h00, EV_FRAME, 16'd1});
    add_row(stream_word(8'h9B), 1'b0, '0);
    add_row(stream_word(8'hFF), 1'b0, '0);
    add_row(stream_word(8'd83), 1'b0, '0);
    add_row(stream_word(8'hAA), 1'b0, '0);
    add_row(stream_word(8'h55), 1'b0, '0);
    add_row(stream_word(8'hEE), 1'b0, '0);
    add_row(read_word(10'd1023), 1'b1, '{8'hAA, EV_OK, 16'd1});
    add_row(read_word(10'd0), 1'b1, '{8'h55, EV_OK, 16'd1});
    add_row(stream_word(8'h98), 1'b0, '0);
    add_row(stream_word(8'h00), 1'b0, '0);
    add_row(stream_word(8'd80), 1'b0, '0);
    add_row(stream_word(8'hFF), 1'b0, '0);
    add_row(read_word(10'd79), 1'b1, '{8'hFF, EV_OK, 16'd1});
    add_row(read_word(10'd80), 1'b1, '{8'h00, EV_OK, 16'd1});
    add_row(stream_word(8'h98), 1'b0, '0);
    add_row(stream_word(8'h10), 1'b0, '0);
    add_row(stream_word(8'h00), 1'b0, '0);
    add_row(stream_word(8'h77), 1'b0, '0);
    add_row(read_word(10'd16), 1'b1, '{8'hFF, EV_OK, 16'd1});
    add_row(stream_word(8'hFF), 1'b1, '{8'h00, EV_FRAME, 16'd2});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 21;
    recv_stall_pct = 84;
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].res);
    queue_packets(500);
    send_queued();
    settle();

    // Window at the bottom of the address space, every non-zero length a literal run.
    program_regs('{16'h0000, 8'd0, 8'h00, 8'hFF});
    send_gap_pct = 84;
    recv_stall_pct = 21;
    queue_packets(500);
    send_queued();
    settle();

    // Window cut short at the top of the address space; both markers share one code.
    program_regs('{16'hFC01, 8'd255, 8'h5A, 8'h5A});
    send_gap_pct = 0;
    recv_stall_pct = 0;
    queue_packets(500);
    send_queued();
    settle();

    // One-entry window with a few packets, then the block halts.
    program_regs('{16'hFFFF, 8'd128, 8'h01, 8'h00});
    queue_packets(40);
    ended_by_marker = $urandom_range(1);
    if (ended_by_marker) begin
      queue_byte(regs_copy.stream_end_code);
    end else begin
      queue_byte(8'hFF);
      queue_byte(8'($urandom_range(254)));
    end
    repeat (40) begin
      if ($urandom_range(1) == 1) stim_words.push_back(read_word(10'($urandom)));
      else stim_words.push_back(stream_word(8'($urandom)));
    end
    send_queued();
    settle();

    $display("Sent %0d words and checked %0d results across four register settings,",
             words_sent, results_seen);
    $display("ending with a halt by %s.",
             ended_by_marker ? "the stream end marker" : "an address outside the window");
    if (faults == 0) begin
      $display("[tilemap_packet_stream_decoder] OK");
    end else begin
      $display("[tilemap_packet_stream_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("[tilemap_packet_stream_decoder] ERROR");
    $finish;
  end

endmodule
